// ----- rtl/vod_pkg.sv -----
// ----------------------------------------------------------------------------
// Velocity oscillation detector package
// Shared widths, codes, payload types and the fixed-point helper functions.
// ----------------------------------------------------------------------------
package vod_pkg;

   // Window geometry
   localparam int WINDOW_DEPTH = 64;
   localparam int HALF_DEPTH   = WINDOW_DEPTH / 2;
   localparam int PTR_W        = $clog2(WINDOW_DEPTH);
   localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

   // Datapath widths
   localparam int SAMPLE_W    = 16;
   localparam int CFG_W       = 16;
   localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW_DEPTH);
   localparam int LIMIT_W     = CFG_W + FILL_W;
   localparam int CMP_W       = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
   localparam int CSR_INDEX_W = 3;
   localparam int PROD_W      = SAMPLE_W + CFG_W + 1;

   // Minimum number of angular sign changes for a detection
   localparam int MIN_CROSSINGS = 2;

   typedef enum logic {
      OP_PUSH  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_INV_FORWARD   = 3'd0,
      REG_INV_BACKWARD  = 3'd1,
      REG_INV_TURN      = 3'd2,
      REG_LINEAR_BOUND  = 3'd3,
      REG_ANGULAR_BOUND = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      SIGN_ZERO = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd2
   } sign_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic [PTR_W-1:0]           ptr_type;
   typedef logic [FILL_W-1:0]          fill_type;
   typedef logic [CFG_W-1:0]           cfg_word_type;

   typedef struct packed {
      cfg_word_type inv_forward_limit;
      cfg_word_type inv_backward_limit;
      cfg_word_type inv_turn_limit;
      cfg_word_type linear_mean_bound;
      cfg_word_type angular_mean_bound;
   } cfg_type;

   typedef struct packed {
      op_type     operation;
      sample_type linear_speed;
      sample_type turn_rate;
   } req_type;

   typedef struct packed {
      op_type     operation;
      sample_type linear_scaled;
      sample_type angular_scaled;
   } scaled_type;

   typedef struct packed {
      fill_type fill_count;
      fill_type crossing_total;
   } status_type;

   // Advance a ring pointer with wrap at the window depth
   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(WINDOW_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // Q8.8 sample times Q4.12 reciprocal, rounded half up into saturated Q4.12.
   // A zero reciprocal means unity gain, which is a shift by four.
   function automatic sample_type scale_q(input sample_type x, input cfg_word_type r);
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] y;
      sample_type               res;
      prod = '0;
      if (r == '0) begin
         y = {{(PROD_W - SAMPLE_W - 4){x[SAMPLE_W-1]}}, x, 4'b0000};
      end else begin
         prod = x * $signed({1'b0, r});
         y    = (prod + PROD_W'(128)) >>> 8;
      end
      if (y > PROD_W'(32767)) begin
         res = 16'sh7FFF;
      end else if (y < -PROD_W'(32768)) begin
         res = 16'sh8000;
      end else begin
         res = y[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   // Three-way sign, zero is a sign of its own
   function automatic sign_type sign_of(input sample_type v);
      sign_type s;
      if (v[SAMPLE_W-1]) begin
         s = SIGN_NEG;
      end else if (v != '0) begin
         s = SIGN_POS;
      end else begin
         s = SIGN_ZERO;
      end
      return s;
   endfunction

endpackage

// ----- rtl/vod_if.sv -----
// ----------------------------------------------------------------------------
// Velocity oscillation detector channels
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vod_req_if;
   import vod_pkg::*;
   logic       valid;
   logic       ready;
   op_type     operation;
   sample_type linear_speed;
   sample_type turn_rate;

   modport source (output valid, operation, linear_speed, turn_rate, input ready);
   modport sink   (input valid, operation, linear_speed, turn_rate, output ready);
endinterface

interface vod_rsp_if;
   logic valid;
   logic ready;
   logic oscillating;

   modport source (output valid, oscillating, input ready);
   modport sink   (input valid, oscillating, output ready);
endinterface

interface vod_csr_if;
   import vod_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   cfg_word_type           data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/vod_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data, read-old on collision.
// ----------------------------------------------------------------------------
module vod_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/vod_scale.sv -----
// ----------------------------------------------------------------------------
// Velocity oscillation detector scaling stage
// Input register, reciprocal scaling with rounding and saturation, stage register.
// ----------------------------------------------------------------------------
module vod_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  vod_pkg::req_type    in_data,
   input  vod_pkg::cfg_type    cfg,
   output logic                out_valid,
   input  logic                out_ready,
   output vod_pkg::scaled_type out_data
);
   import vod_pkg::*;

   logic       in_valid_ff;
   req_type    in_ff;
   logic       out_valid_ff;
   scaled_type out_ff;
   scaled_type out_in;
   logic       out_free;
   logic       advance;
   cfg_word_type lin_recip;

   // Stage handshake
   assign out_free = !out_valid_ff || out_ready;
   assign advance  = in_valid_ff && out_free;
   assign in_ready = !in_valid_ff || advance;

   // Pick the linear reciprocal by direction; zero speed scales to zero anyway
   always_comb begin
      lin_recip = in_ff.linear_speed[SAMPLE_W-1] ? cfg.inv_backward_limit
                                                 : cfg.inv_forward_limit;
      out_in.operation      = in_ff.operation;
      out_in.linear_scaled  = scale_q(in_ff.linear_speed, lin_recip);
      out_in.angular_scaled = scale_q(in_ff.turn_rate, cfg.inv_turn_limit);
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= in_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         in_ff <= in_data;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

// ----- rtl/vod_window.sv -----
// ----------------------------------------------------------------------------
// Velocity oscillation detector window
// Ring window in RAM, running sums, crossing count, detection and result register.
// ----------------------------------------------------------------------------
module vod_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  vod_pkg::scaled_type in_data,
   input  vod_pkg::cfg_type    cfg,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                oscillating,
   output vod_pkg::status_type status
);
   import vod_pkg::*;

   localparam int WORD_W = 2 * SAMPLE_W;

   // Window state
   fill_type fill_ff,   fill_in;
   ptr_type  wp_ff,     wp_in;
   sum_type  lsum_ff,   lsum_in;
   sum_type  asum_ff,   asum_in;
   fill_type cross_ff,  cross_in;
   sign_type last_sign_ff;

   // Result register
   logic rsp_valid_ff;
   logic osc_ff, osc_in;

   // RAM ports
   logic                 take;
   logic                 push;
   logic [WORD_W-1:0]    word_rd;
   ptr_type              mark_rd_addr;
   logic [0:0]           mark_rd;
   logic                 mark_new;
   logic                 fwd_hit_ff;
   logic                 fwd_mark_ff;

   // Update terms
   logic                 full;
   sample_type           old_lin;
   sample_type           old_ang;
   logic                 next_mark;
   logic [SUM_W-1:0]     lin_abs;
   logic [SUM_W-1:0]     ang_abs;
   logic [LIMIT_W-1:0]   lin_limit;
   logic [LIMIT_W-1:0]   ang_limit;

   // Result handshake: update state only when the result register is free
   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;
   assign push     = take && (in_data.operation == OP_PUSH);

   assign old_lin   = word_rd[WORD_W-1:SAMPLE_W];
   assign old_ang   = word_rd[SAMPLE_W-1:0];
   assign next_mark = fwd_hit_ff ? fwd_mark_ff : mark_rd[0];
   assign full      = (fill_ff == FILL_W'(WINDOW_DEPTH));
   assign mark_new  = (fill_ff != '0) && (sign_of(in_data.angular_scaled) != last_sign_ff);

   // Next window state and detection
   always_comb begin
      fill_in   = fill_ff;
      wp_in     = wp_ff;
      lsum_in   = lsum_ff;
      asum_in   = asum_ff;
      cross_in  = cross_ff;
      osc_in    = 1'b0;
      lin_abs   = '0;
      ang_abs   = '0;
      lin_limit = '0;
      ang_limit = '0;
      if (take) begin
         if (in_data.operation == OP_CLEAR) begin
            fill_in  = '0;
            wp_in    = '0;
            lsum_in  = '0;
            asum_in  = '0;
            cross_in = '0;
         end else begin
            // Drop the oldest sample when full; its successor stops counting
            lsum_in  = lsum_ff + SUM_W'(in_data.linear_scaled)
                       - (full ? SUM_W'(old_lin) : SUM_W'(0));
            asum_in  = asum_ff + SUM_W'(in_data.angular_scaled)
                       - (full ? SUM_W'(old_ang) : SUM_W'(0));
            cross_in = cross_ff + FILL_W'(mark_new)
                       - (full ? FILL_W'(next_mark) : FILL_W'(0));
            fill_in  = full ? fill_ff : fill_ff + 1'b1;
            wp_in    = ptr_next(wp_ff);

            lin_abs   = lsum_in[SUM_W-1] ? SUM_W'(-lsum_in) : SUM_W'(lsum_in);
            ang_abs   = asum_in[SUM_W-1] ? SUM_W'(-asum_in) : SUM_W'(asum_in);
            lin_limit = cfg.linear_mean_bound * fill_in;
            ang_limit = cfg.angular_mean_bound * fill_in;
            osc_in    = (fill_in >= FILL_W'(HALF_DEPTH))
                        && (CMP_W'(lin_abs) < CMP_W'(lin_limit))
                        && (CMP_W'(ang_abs) < CMP_W'(ang_limit))
                        && (cross_in >= FILL_W'(MIN_CROSSINGS));
         end
      end
   end

   // Read ahead: slot at the next write pointer and the raw mark just after it
   assign mark_rd_addr = ptr_next(wp_in);

   vod_ram #(.WIDTH(WORD_W), .DEPTH(WINDOW_DEPTH)) u_sample_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wp_ff),
      .wr_data ({in_data.linear_scaled, in_data.angular_scaled}),
      .rd_addr (wp_in),
      .rd_data (word_rd)
   );

   vod_ram #(.WIDTH(1), .DEPTH(WINDOW_DEPTH)) u_mark_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wp_ff),
      .wr_data (mark_new),
      .rd_addr (mark_rd_addr),
      .rd_data (mark_rd)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         wp_ff        <= '0;
         lsum_ff      <= '0;
         asum_ff      <= '0;
         cross_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         wp_ff      <= wp_in;
         lsum_ff    <= lsum_in;
         asum_ff    <= asum_in;
         cross_ff   <= cross_in;
         fwd_hit_ff <= push && (mark_rd_addr == wp_ff);
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fwd_mark_ff <= mark_new;
      if (push) begin
         last_sign_ff <= sign_of(in_data.angular_scaled);
      end
      if (take) begin
         osc_ff <= osc_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign oscillating           = osc_ff;
   assign status.fill_count     = fill_ff;
   assign status.crossing_total = cross_ff;

endmodule

// ----- rtl/velocity_oscillation_detector.sv -----
// ----------------------------------------------------------------------------
// Velocity oscillation detector
// Sliding-window detector of back-and-forth motion from velocity samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one transaction per update: operation (push or clear),
//   linear_speed and turn_rate as signed Q8.8. rsp_chan returns exactly one
//   transaction per request with the oscillating flag; a clear answers 0.
//   csr_chan writes the five Q4.12 registers (index 0..4); other indexes are
//   dropped. Write registers only while no request is in flight.
//   Path: an accepted request lands in the input register, then in the scaling
//   register and then in the result register, which drives the response.
//   Throughput: one transaction per cycle while rsp_chan does not stall; the
//   window update is a single read-modify-write of one ring slot, with the
//   old slot and the next crossing mark read ahead from two RAMs.
//   Reset empties the window and zeroes the five registers; no clearing pass runs.
//   When rsp_chan stalls, the result register holds, the window state holds,
//   and the two stages ahead keep taking requests until they fill; then
//   req_chan.ready drops.
// ----------------------------------------------------------------------------
module velocity_oscillation_detector (
   input logic      clock,
   input logic      reset,
   vod_req_if.sink  req_chan,
   vod_rsp_if.source rsp_chan,
   vod_csr_if.sink  csr_chan
);
   import vod_pkg::*;

   cfg_type    cfg_ff;
   req_type    req_data;
   logic       sc_valid;
   logic       sc_ready;
   scaled_type sc_data;
   status_type status;

   // Register writes are always taken
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_INV_FORWARD:   cfg_ff.inv_forward_limit  <= csr_chan.data;
            REG_INV_BACKWARD:  cfg_ff.inv_backward_limit <= csr_chan.data;
            REG_INV_TURN:      cfg_ff.inv_turn_limit     <= csr_chan.data;
            REG_LINEAR_BOUND:  cfg_ff.linear_mean_bound  <= csr_chan.data;
            REG_ANGULAR_BOUND: cfg_ff.angular_mean_bound <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Gather request payload
   assign req_data.operation    = req_chan.operation;
   assign req_data.linear_speed = req_chan.linear_speed;
   assign req_data.turn_rate    = req_chan.turn_rate;

   vod_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (sc_valid),
      .out_ready (sc_ready),
      .out_data  (sc_data)
   );

   vod_window u_window (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sc_valid),
      .in_ready    (sc_ready),
      .in_data     (sc_data),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .oscillating (rsp_chan.oscillating),
      .status      (status)
   );

   // Fill count never passes the window depth
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      status.fill_count <= FILL_W'(WINDOW_DEPTH))
      else $error("fill count beyond window depth");

   // The oldest sample never carries a crossing
   a_cross_bound: assert property (@(posedge clock) disable iff (reset)
      (status.crossing_total == '0) || (status.crossing_total < status.fill_count))
      else $error("crossing total not below fill count");

   // A raised flag matches the window it was computed from
   a_flag_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.oscillating) |->
         ((status.fill_count >= FILL_W'(HALF_DEPTH))
          && (status.crossing_total >= FILL_W'(MIN_CROSSINGS))))
      else $error("oscillation flag without a qualifying window");

   // A stalled response freezes the window
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         ($stable(status.fill_count) && $stable(status.crossing_total)))
      else $error("window changed while response stalled");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Velocity oscillation detector testbench
// Walks a short table of edge-case requests, then long random runs of swaying,
// drifting and noisy velocity samples under several register settings. Every
// response is checked against a cycle-free window model or a row's literal flag.
// ----------------------------------------------------------------------------
module tb_top;
   import vod_pkg::*;

   localparam int REG_COUNT       = 5;
   localparam int CSR_SLOTS       = 1 << CSR_INDEX_W;
   localparam int PHASES          = 7;
   localparam int ITEMS_PER_PHASE = 78;
   localparam int RESET_ROWS      = 6;
   localparam int DIRECTED_ROWS   = 18;
   localparam int DRAIN_CYCLES    = 6;

   typedef enum {SEG_SWAY, SEG_DRIFT, SEG_NOISE} segment_kind_type;

   typedef struct {
      op_type     op;
      sample_type lin;
      sample_type ang;
      bit         literal;
      bit         literal_flag;
   } step_row_type;

   logic clock;
   logic reset;

   vod_req_if req_chan ();
   vod_rsp_if rsp_chan ();
   vod_csr_if csr_chan ();

   velocity_oscillation_detector u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Directed rows: the first group runs with the registers at reset (all zero
   // bounds, so nothing can be flagged), the rest under a lopsided setting.
   step_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_PUSH,  16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0},  // unity gain saturates high
      '{OP_PUSH,  16'sh8000, 16'sh8000, 1'b1, 1'b0},  // unity gain saturates low
      '{OP_PUSH,  16'sh0000, 16'sh0000, 1'b1, 1'b0},  // zero is a sign of its own
      '{OP_PUSH,  16'sh0001, 16'shFFFF, 1'b1, 1'b0},
      '{OP_CLEAR, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0},  // clear ignores its payload
      '{OP_PUSH,  16'sh0100, 16'sh0100, 1'b1, 1'b0},  // first sample carries no mark
      '{OP_PUSH,  16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0},
      '{OP_PUSH,  16'sh8000, 16'sh8000, 1'b0, 1'b0},
      '{OP_PUSH,  16'sh0001, 16'sh0000, 1'b0, 1'b0},
      '{OP_PUSH,  16'shFFFF, 16'sh0001, 1'b0, 1'b0},
      '{OP_PUSH,  16'shFF80, 16'shFFFF, 1'b0, 1'b0},  // half-way tie rounds up
      '{OP_PUSH,  16'shFE80, 16'sh8000, 1'b0, 1'b0},
      '{OP_PUSH,  16'sh0080, 16'sh0000, 1'b0, 1'b0},
      '{OP_PUSH,  16'sh0000, 16'sh7FFF, 1'b0, 1'b0},
      '{OP_CLEAR, 16'sh1234, 16'shEDCC, 1'b1, 1'b0},
      '{OP_CLEAR, 16'sh0000, 16'sh0000, 1'b1, 1'b0},  // clear of an empty window
      '{OP_PUSH,  16'sh0000, 16'sh0001, 1'b0, 1'b0},
      '{OP_PUSH,  16'sh0000, 16'shFFFF, 1'b0, 1'b0}
   };

   // Window model state
   cfg_type    gain_cfg = '0;
   sample_type lin_ring  [WINDOW_DEPTH];
   sample_type ang_ring  [WINDOW_DEPTH];
   bit         mark_ring [WINDOW_DEPTH];
   int         ring_fill    = 0;
   int         ring_head    = 0;
   longint     lin_total    = 0;
   longint     ang_total    = 0;
   int         turn_changes = 0;
   bit         flag_expect_q [$];

   // Sender side of the directed table, driven with the payload
   bit row_literal;
   bit row_literal_flag;

   // Traffic shaping
   int               burst_left = 0;
   int               stall_tick = 0;
   segment_kind_type seg_kind   = SEG_SWAY;
   int               seg_left   = 0;
   int               sway_sign  = 1;
   int               drift_dir  = 1;

   // Run statistics
   int push_count      = 0;
   int clear_count     = 0;
   int result_count    = 0;
   int flagged_count   = 0;
   int reg_write_count = 0;
   int setting_count   = 0;
   int mismatch_count  = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Q8.8 sample times Q4.12 reciprocal into saturated Q4.12
   function automatic sample_type apply_gain(input sample_type x, input cfg_word_type r);
      longint y;
      if (r == '0) begin
         y = longint'(x) * 16;
      end else begin
         y = (longint'(x) * longint'(r) + 128) >>> 8;
      end
      if (y > 32767) begin
         y = 32767;
      end else if (y < -32768) begin
         y = -32768;
      end
      return sample_type'(y);
   endfunction

   function automatic int sign3(input sample_type v);
      int s;
      if (v < 0) begin
         s = -1;
      end else if (v > 0) begin
         s = 1;
      end else begin
         s = 0;
      end
      return s;
   endfunction

   // Apply one request to the window model and return the oscillating flag
   function automatic bit advance_window(input op_type op, input sample_type lin,
                                         input sample_type ang);
      sample_type s_lin;
      sample_type s_ang;
      int         nxt;
      int         prv;
      bit         mark;
      longint     n;
      longint     lin_mag;
      longint     ang_mag;
      if (op == OP_CLEAR) begin
         ring_fill    = 0;
         ring_head    = 0;
         lin_total    = 0;
         ang_total    = 0;
         turn_changes = 0;
         return 1'b0;
      end
      if (lin > 0) begin
         s_lin = apply_gain(lin, gain_cfg.inv_forward_limit);
      end else if (lin < 0) begin
         s_lin = apply_gain(lin, gain_cfg.inv_backward_limit);
      end else begin
         s_lin = '0;
      end
      s_ang = apply_gain(ang, gain_cfg.inv_turn_limit);
      // drop the oldest sample; the one after it becomes oldest and loses its mark
      if (ring_fill >= WINDOW_DEPTH) begin
         nxt = (ring_head + 1) % WINDOW_DEPTH;
         lin_total    -= lin_ring[ring_head];
         ang_total    -= ang_ring[ring_head];
         turn_changes -= int'(mark_ring[ring_head]);
         turn_changes -= int'(mark_ring[nxt]);
         mark_ring[nxt] = 1'b0;
         ring_fill = WINDOW_DEPTH - 1;
      end
      mark = 1'b0;
      if (ring_fill > 0) begin
         prv  = (ring_head + WINDOW_DEPTH - 1) % WINDOW_DEPTH;
         mark = (sign3(ang_ring[prv]) != sign3(s_ang));
      end
      lin_ring[ring_head]  = s_lin;
      ang_ring[ring_head]  = s_ang;
      mark_ring[ring_head] = mark;
      lin_total    += s_lin;
      ang_total    += s_ang;
      turn_changes += int'(mark);
      ring_fill++;
      ring_head = (ring_head + 1) % WINDOW_DEPTH;
      n       = ring_fill;
      lin_mag = (lin_total < 0) ? -lin_total : lin_total;
      ang_mag = (ang_total < 0) ? -ang_total : ang_total;
      return (ring_fill >= HALF_DEPTH)
             && (lin_mag < longint'(gain_cfg.linear_mean_bound) * n)
             && (ang_mag < longint'(gain_cfg.angular_mean_bound) * n)
             && (turn_changes >= MIN_CROSSINGS);
   endfunction

   // Register setting for each random phase, extremes first
   function automatic cfg_type pick_setting(input int phase);
      cfg_type s;
      case (phase)
      0: s = '0;
      1: s = '1;
      2: begin
         s.inv_forward_limit  = cfg_word_type'(1);
         s.inv_backward_limit = cfg_word_type'(1);
         s.inv_turn_limit     = cfg_word_type'(1);
         s.linear_mean_bound  = cfg_word_type'($urandom_range(0, 64));
         s.angular_mean_bound = cfg_word_type'($urandom_range(0, 64));
      end
      default: begin
         s.inv_forward_limit  = ($urandom_range(0, 5) == 0) ? '0
                                : cfg_word_type'($urandom_range(64, 8192));
         s.inv_backward_limit = ($urandom_range(0, 5) == 0) ? '0
                                : cfg_word_type'($urandom_range(64, 8192));
         s.inv_turn_limit     = ($urandom_range(0, 5) == 0) ? '0
                                : cfg_word_type'($urandom_range(64, 8192));
         s.linear_mean_bound  = cfg_word_type'($urandom_range(16, 4096));
         s.angular_mean_bound = cfg_word_type'($urandom_range(16, 4096));
      end
      endcase
      return s;
   endfunction

   // Offer one request, opening a new burst after a random gap when due
   task automatic send_request(input op_type op, input sample_type lin, input sample_type ang,
                               input bit literal, input bit literal_flag);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.linear_speed <= lin;
      req_chan.turn_rate    <= ang;
      row_literal           <= literal;
      row_literal_flag      <= literal_flag;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // Hold valid across back-to-back writes; drop it after the last one
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input cfg_word_type data,
                            input bit last);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      if (last) begin
         csr_chan.valid <= 1'b0;
      end
   endtask

   task automatic program_registers(input cfg_type s);
      // an index past the register file must be dropped
      write_csr(CSR_INDEX_W'($urandom_range(REG_COUNT, CSR_SLOTS - 1)),
                cfg_word_type'($urandom), 1'b0);
      write_csr(REG_INV_FORWARD,   s.inv_forward_limit,  1'b0);
      write_csr(REG_INV_BACKWARD,  s.inv_backward_limit, 1'b0);
      write_csr(REG_INV_TURN,      s.inv_turn_limit,     1'b0);
      write_csr(REG_LINEAR_BOUND,  s.linear_mean_bound,  1'b0);
      write_csr(REG_ANGULAR_BOUND, s.angular_mean_bound, 1'b1);
      setting_count++;
   endtask

   // Stop sending and let every outstanding response arrive
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (flag_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly swaying segments that fill and wrap the window, with drift and noise
   task automatic run_random(input int count);
      op_type     op;
      sample_type lin;
      sample_type ang;
      int         jit;
      int         amp;
      int         pick;
      repeat (count) begin
         if (seg_left == 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
               seg_kind = SEG_SWAY;
               seg_left = $urandom_range(30, 90);
            end else if (pick < 15) begin
               seg_kind  = SEG_DRIFT;
               seg_left  = $urandom_range(4, 16);
               drift_dir = ($urandom_range(0, 1) == 0) ? 1 : -1;
            end else begin
               seg_kind = SEG_NOISE;
               seg_left = $urandom_range(3, 12);
            end
         end
         seg_left--;
         op = OP_PUSH;
         case (seg_kind)
         SEG_SWAY: begin
            jit = 1 << $urandom_range(0, 9);
            lin = sample_type'(int'($urandom_range(0, 2 * jit)) - jit);
            if ($urandom_range(0, 9) < 7) begin
               sway_sign = -sway_sign;
            end
            amp = $urandom_range(1, (1 << $urandom_range(1, 15)) - 1);
            ang = sample_type'(sway_sign * amp);
            if ($urandom_range(0, 11) == 0) begin
               ang = '0;
            end
            if ($urandom_range(0, 199) == 0) begin
               op = OP_CLEAR;
            end
         end
         SEG_DRIFT: begin
            lin = sample_type'(drift_dir * int'($urandom_range(256, 32767)));
            ang = sample_type'(drift_dir * int'($urandom_range(0, 4000)));
         end
         default: begin
            op  = ($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_PUSH;
            lin = sample_type'($urandom);
            ang = sample_type'($urandom);
         end
         endcase
         send_request(op, lin, ang, 1'b0, 1'b0);
      end
   endtask

   // Response stalls: steady, sparse, periodic and coin-flip stretches
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      case ((stall_tick / 97) % 4)
      0: rsp_chan.ready <= 1'b1;
      1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      2: rsp_chan.ready <= ((stall_tick % 7) < 3);
      default: rsp_chan.ready <= ($urandom_range(0, 1) != 0);
      endcase
   end

   // Track register writes, predict each request, check each response
   always @(posedge clock) begin : window_check
      bit want;
      bit flag;
      if (!reset) begin
         // check before predicting so a stray response is never masked
         if (rsp_chan.valid && rsp_chan.ready) begin
            result_count++;
            if (rsp_chan.oscillating === 1'b1) begin
               flagged_count++;
            end
            if (flag_expect_q.size() == 0) begin
               $display("%0t: response with none outstanding, expected nothing, got %b",
                        $time, rsp_chan.oscillating);
               mismatch_count++;
            end else begin
               want = flag_expect_q.pop_front();
               if (rsp_chan.oscillating !== want) begin
                  $display("%0t: oscillating mismatch, expected %b, got %b",
                           $time, want, rsp_chan.oscillating);
                  mismatch_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            flag = advance_window(req_chan.operation, req_chan.linear_speed,
                                  req_chan.turn_rate);
            if (row_literal) begin
               flag = row_literal_flag;
            end
            flag_expect_q = {flag_expect_q, flag};
            if (req_chan.operation == OP_CLEAR) begin
               clear_count++;
            end else begin
               push_count++;
            end
         end
         if (csr_chan.valid && csr_chan.ready) begin
            reg_write_count++;
            case (csr_chan.index)
            REG_INV_FORWARD:   gain_cfg.inv_forward_limit  = csr_chan.data;
            REG_INV_BACKWARD:  gain_cfg.inv_backward_limit = csr_chan.data;
            REG_INV_TURN:      gain_cfg.inv_turn_limit     = csr_chan.data;
            REG_LINEAR_BOUND:  gain_cfg.linear_mean_bound  = csr_chan.data;
            REG_ANGULAR_BOUND: gain_cfg.angular_mean_bound = csr_chan.data;
            default: ;
            endcase
         end
      end
   end

   initial begin
      int      r;
      int      p;
      cfg_type lopsided;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.operation    <= OP_PUSH;
      req_chan.linear_speed <= '0;
      req_chan.turn_rate    <= '0;
      row_literal           <= 1'b0;
      row_literal_flag      <= 1'b0;
      csr_chan.valid        <= 1'b0;
      csr_chan.index        <= '0;
      csr_chan.data         <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table, switching to the lopsided setting part way through
      for (r = 0; r < DIRECTED_ROWS; r++) begin
         if (r == RESET_ROWS) begin
            drain_results();
            lopsided.inv_forward_limit  = 16'hFFFF;
            lopsided.inv_backward_limit = 16'h0001;
            lopsided.inv_turn_limit     = 16'h0801;
            lopsided.linear_mean_bound  = 16'hFFFF;
            lopsided.angular_mean_bound = 16'hFFFF;
            program_registers(lopsided);
         end
         send_request(directed_rows[r].op, directed_rows[r].lin, directed_rows[r].ang,
                      directed_rows[r].literal, directed_rows[r].literal_flag);
      end

      // random phases, each under its own setting
      for (p = 0; p < PHASES; p++) begin
         drain_results();
         program_registers(pick_setting(p));
         run_random(ITEMS_PER_PHASE);
      end
      drain_results();

      $display("Covered %0d pushes and %0d clears under %0d register settings (%0d writes).",
               push_count, clear_count, setting_count, reg_write_count);
      $display("Checked %0d responses, %0d flagging oscillation, %0d mismatches.",
               result_count, flagged_count, mismatch_count);
      if (mismatch_count == 0 && flag_expect_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog against a hung handshake
   initial begin : watchdog
      #5_000_000;
      $display("Run timed out with %0d responses outstanding.", flag_expect_q.size());
      $display("FAILURE");
      $finish;
   end

endmodule
